// ----- rtl/core/text_console_writer_core_defines.svh -----
// Assertion macros for the text console writer core.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TCW_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/tcw_pkg.sv -----
// Shared constants and types of the text console writer.
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam int CMD_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int CELL_W   = 16;
	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int CURROW_W = ($clog2(ROWS) > ROW_W) ? $clog2(ROWS) : ROW_W;

	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE     = 2'd0,
		CMD_BACKSPACE = 2'd1,
		CMD_CLEAR     = 2'd2,
		CMD_READ      = 2'd3
	} tcw_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_FLUSH,
		ST_READ,
		ST_DONE
	} tcw_state_t;

endpackage

// ----- rtl/core/tcw_cmd_if.sv -----
// Command channel of the text console writer.
interface tcw_cmd_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CHAR_W-1:0] char_code;
	logic [ROW_W-1:0]  cell_row;
	logic [COL_W-1:0]  cell_col;

	modport source (output valid, command, char_code, cell_row, cell_col, input ready);
	modport sink (input valid, command, char_code, cell_row, cell_col, output ready);

endinterface

// ----- rtl/core/tcw_rsp_if.sv -----
// Response channel of the text console writer.
interface tcw_rsp_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_value;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;

	modport source (output valid, cell_value, cursor_col, cursor_row, input ready);
	modport sink (input valid, cell_value, cursor_col, cursor_row, output ready);

endinterface

// ----- rtl/core/text_console_writer_core.sv -----
// Text console writer core: screen cell memory, cursor and command sequencer.
// Every command transaction yields one response transaction carrying the read cell
// (zero unless reading) and the cursor after the command. A character write, a
// backspace or a newline without scroll goes straight to the done state; a read
// passes the read state first. A scroll moves every row up one cell at a time
// through the single read and write port of the cell memory, then passes the
// flush state; a clear rewrites every cell, one per cycle. After reset a clearing
// pass fills the memory with blank cells of attribute 0x0F, during which no
// command is taken. A response waiting on the output does not hold off the next
// command. The user must write the attribute register only while the core is
// idle; the core itself does not enforce this.
`include "text_console_writer_core_defines.svh"

module text_console_writer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	tcw_cmd_if.sink                    cmd,
	tcw_rsp_if.source                  rsp,
	input  logic                       cfg_wr_en,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_wr_data
);
	import tcw_pkg::*;

	tcw_state_t          state_q;
	tcw_state_t          state_d;
	logic [ATTR_W-1:0]   attr_q;
	logic                init_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [COL_W-1:0]    cursor_col_q;
	logic [CURROW_W-1:0] cursor_row_q;
	logic [ADDR_W-1:0]   cursor_base_q;
	logic                rsp_vld_q;
	logic [CELL_W-1:0]   rsp_value_q;
	logic [COL_W-1:0]    rsp_col_q;
	logic [ROW_W-1:0]    rsp_row_q;
	logic [CELL_W-1:0]   value_q;
	logic                rng_q;

	logic                mv_vld_s1;
	logic [ADDR_W-1:0]   mv_addr_s1;
	logic                mv_copy_s1;

	logic [CELL_W-1:0]   screen_q [CELL_COUNT];
	logic [CELL_W-1:0]   rd_data_q;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [CELL_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;

	logic                accept_c;
	logic                load_c;
	logic                newline_c;
	logic [COL_W:0]      col_inc_c;
	logic                wrap_c;
	logic                advance_c;
	logic                last_row_c;
	logic                last_idx_c;
	logic                copy_c;
	logic                in_range_c;
	logic [ADDR_W-1:0]   read_addr_c;
	logic [ADDR_W-1:0]   cur_addr_c;
	logic [COL_W-1:0]    col_dec_c;
	logic [CELL_W-1:0]   blank_c;
	tcw_cmd_t            cmd_c;

	assign cmd_c       = tcw_cmd_t'(cmd.command);
	assign accept_c    = cmd.valid && cmd.ready;
	assign load_c      = !rsp_vld_q || rsp.ready;
	assign newline_c   = cmd.char_code == NEWLINE_CHAR;
	assign col_inc_c   = {1'b0, cursor_col_q} + (COL_W + 1)'(1);
	assign wrap_c      = col_inc_c == (COL_W + 1)'(COLUMNS);
	assign advance_c   = newline_c || wrap_c;
	assign last_row_c  = cursor_row_q == CURROW_W'(ROWS - 1);
	assign last_idx_c  = idx_q == ADDR_W'(CELL_COUNT - 1);
	assign copy_c      = int'(idx_q) < MOVE_COUNT;
	assign in_range_c  = (int'(cmd.cell_row) < ROWS) && (int'(cmd.cell_col) < COLUMNS);
	assign read_addr_c = ADDR_W'(cmd.cell_row) * ADDR_W'(COLUMNS) + ADDR_W'(cmd.cell_col);
	assign col_dec_c   = cursor_col_q - COL_W'(1);
	assign cur_addr_c  = cursor_base_q + ADDR_W'(cursor_col_q);
	assign blank_c     = {(init_q ? ATTR_RESET : attr_q), BLANK_CHAR};

	assign rsp.valid      = rsp_vld_q;
	assign rsp.cell_value = rsp_value_q;
	assign rsp.cursor_col = rsp_col_q;
	assign rsp.cursor_row = rsp_row_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (last_idx_c) begin
					state_d = init_q ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					unique case (cmd_c)
						CMD_WRITE:     state_d = (advance_c && last_row_c) ? ST_SCROLL : ST_DONE;
						CMD_BACKSPACE: state_d = ST_DONE;
						CMD_CLEAR:     state_d = ST_CLEAR;
						CMD_READ:      state_d = ST_READ;
						default:       state_d = ST_DONE;
					endcase
				end
			end
			ST_SCROLL: begin
				if (last_idx_c) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_DONE;
			ST_READ:  state_d = ST_DONE;
			ST_DONE: begin
				if (load_c) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = blank_c;
		mem_re    = 1'b0;
		mem_raddr = read_addr_c;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					unique case (cmd_c)
						CMD_WRITE: begin
							mem_we    = !newline_c;
							mem_waddr = cur_addr_c;
							mem_wdata = {attr_q, cmd.char_code};
						end
						CMD_BACKSPACE: begin
							mem_we    = cursor_col_q != '0;
							mem_waddr = cursor_base_q + ADDR_W'(col_dec_c);
						end
						CMD_READ: begin
							mem_re = in_range_c;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCROLL: begin
				mem_re    = copy_c;
				mem_raddr = idx_q + ADDR_W'(COLUMNS);
			end
			default: begin
			end
		endcase
		if (mv_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = mv_addr_s1;
			mem_wdata = mv_copy_s1 ? rd_data_q : blank_c;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= screen_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			attr_q        <= ATTR_RESET;
			init_q        <= 1'b1;
			idx_q         <= '0;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			cursor_base_q <= '0;
			rsp_vld_q     <= 1'b0;
			mv_vld_s1     <= 1'b0;
		end else begin
			state_q   <= state_d;
			mv_vld_s1 <= state_q == ST_SCROLL;
			if (cfg_wr_en) begin
				attr_q <= cfg_wr_data;
			end
			if (state_q == ST_DONE && load_c) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (state_q == ST_CLEAR || state_q == ST_SCROLL) begin
				idx_q <= last_idx_c ? '0 : idx_q + ADDR_W'(1);
				if (state_q == ST_CLEAR && last_idx_c) begin
					init_q <= 1'b0;
				end
			end
			if (accept_c) begin
				unique case (cmd_c)
					CMD_WRITE: begin
						if (advance_c) begin
							cursor_col_q <= '0;
							if (!last_row_c) begin
								cursor_row_q  <= cursor_row_q + CURROW_W'(1);
								cursor_base_q <= cursor_base_q + ADDR_W'(COLUMNS);
							end
						end else begin
							cursor_col_q <= col_inc_c[COL_W-1:0];
						end
					end
					CMD_BACKSPACE: begin
						if (cursor_col_q != '0) begin
							cursor_col_q <= col_dec_c;
						end
					end
					CMD_CLEAR: begin
						cursor_col_q  <= '0;
						cursor_row_q  <= '0;
						cursor_base_q <= '0;
						idx_q         <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		mv_addr_s1 <= idx_q;
		mv_copy_s1 <= copy_c;
		if (accept_c) begin
			value_q <= '0;
			rng_q   <= in_range_c;
		end
		if (state_q == ST_READ) begin
			value_q <= rng_q ? rd_data_q : '0;
		end
		if (state_q == ST_DONE && load_c) begin
			rsp_value_q <= value_q;
			rsp_col_q   <= cursor_col_q;
			rsp_row_q   <= cursor_row_q[ROW_W-1:0];
		end
	end

	`TCW_ASSERT(a_col_range, int'(cursor_col_q) < COLUMNS, "Cursor column left the screen.")
	`TCW_ASSERT(a_base_match, cursor_base_q == ADDR_W'(cursor_row_q) * ADDR_W'(COLUMNS), "Row base does not match cursor row.")
	`TCW_ASSERT_IMPLY(a_scroll_cursor, state_q == ST_SCROLL, last_row_c && cursor_col_q == '0, "Scroll with cursor off the bottom row start.")
	`TCW_ASSERT_IMPLY(a_move_window, mv_vld_s1, state_q == ST_SCROLL || state_q == ST_FLUSH, "Scroll write outside the scroll sequence.")
	`TCW_ASSERT_IMPLY(a_rsp_source, $rose(rsp_vld_q), $past(state_q) == ST_DONE, "Response raised outside the completion state.")

endmodule
